[design/tar_archive_stream_deframer_defines.svh]
// assertion macros for the tar archive stream deframer
`ifndef TAR_ARCHIVE_STREAM_DEFRAMER_DEFINES_SVH
`define TAR_ARCHIVE_STREAM_DEFRAMER_DEFINES_SVH

// same-cycle implication, clocked on clk, held off during reset
`define TASD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tar deframer assertion failed");

// next-cycle implication, clocked on clk, held off during reset
`define TASD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tar deframer assertion failed");

`endif

[design/tasd_pkg.sv]
// shared constants for the tar archive stream deframer
`default_nettype none
package tasd_pkg;

    localparam int BLOCK_BYTES      = 512;
    localparam int OFF_W            = 9;
    localparam int SIZE_W           = 36;
    localparam int SIZE_FIELD_START = 124;
    localparam int SIZE_FIELD_BYTES = 12;
    localparam int TDATA_W          = 56;
    localparam int TUSER_W          = 4;

    // block phase, also the byte kind reported on the output
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_PAD     = 2'd2;
    localparam logic [1:0] KIND_ENDED   = 2'd3;

    // size field parse stage
    localparam logic [1:0] PS_SKIP    = 2'd0;
    localparam logic [1:0] PS_COLLECT = 2'd1;
    localparam logic [1:0] PS_STOP    = 2'd2;

endpackage
`default_nettype wire

[design/tar_archive_stream_deframer.sv]
// tar archive stream deframer: byte classification for a ustar stream
//
// s_axis carries the archive one byte per word. m_axis gives one word per
// input byte: the byte itself, its kind, its offset in a header block, the
// parsed member size on the last header byte, and flags for the end of a
// header, the last payload byte (tlast) and the end of the archive.
// Each accepted byte is held in an input register, classified by one
// stage of logic and written to the output register. Throughput is one
// byte per cycle while the receiver keeps m_axis_tready high;
// the state update (block offset, 36-bit payload count and the
// octal size accumulator) is the loop that sets that rate.
// When the receiver holds m_axis_tready low the output word waits, the
// input register fills, and s_axis_tready drops until the output moves.
// Reset puts the block in the header phase at offset zero with an empty
// size accumulator and both stages empty; after an all-zero header block
// every byte is reported with the ended kind until the next reset.
`default_nettype none
`include "tar_archive_stream_deframer_defines.svh"
module tar_archive_stream_deframer #(
    parameter int SIZE_FIELD_BYTES = tasd_pkg::SIZE_FIELD_BYTES
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [7:0]                   s_axis_tdata,  // data_byte[7:0]
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // byte_out[7:0], header_offset[16:8], payload_size[52:17], zero fill
    output logic [tasd_pkg::TDATA_W-1:0]      m_axis_tdata,
    // byte_kind[1:0], header_done[2], archive_end[3]
    output logic [tasd_pkg::TUSER_W-1:0]      m_axis_tuser,
    output logic                              m_axis_tlast   // payload_last
);

    localparam int OFF_W  = tasd_pkg::OFF_W;
    localparam int SIZE_W = tasd_pkg::SIZE_W;
    localparam logic [OFF_W-1:0] FIELD_FIRST = OFF_W'(tasd_pkg::SIZE_FIELD_START);
    localparam logic [OFF_W-1:0] FIELD_END   =
        OFF_W'(tasd_pkg::SIZE_FIELD_START + SIZE_FIELD_BYTES);
    localparam logic [OFF_W-1:0] LAST_OFF    = OFF_W'(tasd_pkg::BLOCK_BYTES - 1);

    // pipeline control
    logic       advance;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;

    // parser state
    logic [1:0]        phase_reg,       phase_next;
    logic [OFF_W-1:0]  block_off_reg,   block_off_next;
    logic [SIZE_W-1:0] size_acc_reg,    size_acc_next;
    logic [1:0]        parse_stage_reg, parse_stage_next;
    logic              all_zero_reg,    all_zero_next;
    logic [SIZE_W-1:0] pay_rem_reg,     pay_rem_next;
    logic [OFF_W-1:0]  pad_rem_reg,     pad_rem_next;

    // result fields
    logic [1:0]        kind_next;
    logic [OFF_W-1:0]  hoff_next;
    logic              hdone_next;
    logic [SIZE_W-1:0] psize_next;
    logic              plast_next;
    logic              aend_next;

    logic [7:0]        byte_out_reg;
    logic [1:0]        kind_reg;
    logic [OFF_W-1:0]  hoff_reg;
    logic              hdone_reg;
    logic [SIZE_W-1:0] psize_reg;
    logic              plast_reg;
    logic              aend_reg;

    logic       in_field;
    logic       is_space;
    logic       is_octal;
    logic       hdr_zero;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    assign is_space = (in_byte_reg == 8'h20) || (in_byte_reg >= 8'h09 && in_byte_reg <= 8'h0d);
    assign is_octal = (in_byte_reg[7:3] == 5'b00110);
    assign in_field = (block_off_reg >= FIELD_FIRST) && (block_off_reg < FIELD_END);
    assign hdr_zero = all_zero_reg && (in_byte_reg == 8'h00);

    always_comb
    begin
        phase_next       = phase_reg;
        block_off_next   = block_off_reg;
        size_acc_next    = size_acc_reg;
        parse_stage_next = parse_stage_reg;
        all_zero_next    = all_zero_reg;
        pay_rem_next     = pay_rem_reg;
        pad_rem_next     = pad_rem_reg;
        kind_next        = phase_reg;
        hoff_next        = '0;
        hdone_next       = 1'b0;
        psize_next       = '0;
        plast_next       = 1'b0;
        aend_next        = 1'b0;

        case (phase_reg)
            tasd_pkg::KIND_HEADER:
            begin
                hoff_next     = block_off_reg;
                all_zero_next = hdr_zero;
                if (in_field)
                begin
                    // whitespace only skipped ahead of the first digit
                    if (parse_stage_reg == tasd_pkg::PS_SKIP && !is_space)
                    begin
                        parse_stage_next = tasd_pkg::PS_COLLECT;
                    end
                    if (parse_stage_next == tasd_pkg::PS_COLLECT)
                    begin
                        if (is_octal)
                        begin
                            size_acc_next = {size_acc_reg[SIZE_W-4:0], in_byte_reg[2:0]};
                        end
                        else
                        begin
                            parse_stage_next = tasd_pkg::PS_STOP;
                        end
                    end
                end
                if (block_off_reg == LAST_OFF)
                begin
                    if (hdr_zero)
                    begin
                        aend_next  = 1'b1;
                        phase_next = tasd_pkg::KIND_ENDED;
                    end
                    else
                    begin
                        hdone_next   = 1'b1;
                        psize_next   = size_acc_next;
                        pay_rem_next = size_acc_next;
                        // padding up to the next block boundary
                        pad_rem_next = OFF_W'(~size_acc_next[OFF_W-1:0] + 1'b1);
                        phase_next   = (size_acc_next != '0) ? tasd_pkg::KIND_PAYLOAD
                                                             : tasd_pkg::KIND_HEADER;
                    end
                    block_off_next   = '0;
                    size_acc_next    = '0;
                    parse_stage_next = tasd_pkg::PS_SKIP;
                    all_zero_next    = 1'b1;
                end
                else
                begin
                    block_off_next = block_off_reg + 1'b1;
                end
            end
            tasd_pkg::KIND_PAYLOAD:
            begin
                if (pay_rem_reg[SIZE_W-1:1] == '0)
                begin
                    plast_next   = 1'b1;
                    pay_rem_next = '0;
                    phase_next   = (pad_rem_reg != '0) ? tasd_pkg::KIND_PAD
                                                       : tasd_pkg::KIND_HEADER;
                end
                else
                begin
                    pay_rem_next = pay_rem_reg - 1'b1;
                end
            end
            tasd_pkg::KIND_PAD:
            begin
                if (pad_rem_reg[OFF_W-1:1] == '0)
                begin
                    pad_rem_next = '0;
                    phase_next   = tasd_pkg::KIND_HEADER;
                end
                else
                begin
                    pad_rem_next = pad_rem_reg - 1'b1;
                end
            end
            default:
            begin
                phase_next = tasd_pkg::KIND_ENDED;
            end
        endcase
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // parser state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            phase_reg       <= tasd_pkg::KIND_HEADER;
            block_off_reg   <= '0;
            size_acc_reg    <= '0;
            parse_stage_reg <= tasd_pkg::PS_SKIP;
            all_zero_reg    <= 1'b1;
            pay_rem_reg     <= '0;
            pad_rem_reg     <= '0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                phase_reg       <= phase_next;
                block_off_reg   <= block_off_next;
                size_acc_reg    <= size_acc_next;
                parse_stage_reg <= parse_stage_next;
                all_zero_reg    <= all_zero_next;
                pay_rem_reg     <= pay_rem_next;
                pad_rem_reg     <= pad_rem_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            byte_out_reg <= in_byte_reg;
            kind_reg     <= kind_next;
            hoff_reg     <= hoff_next;
            hdone_reg    <= hdone_next;
            psize_reg    <= psize_next;
            plast_reg    <= plast_next;
            aend_reg     <= aend_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(tasd_pkg::TDATA_W - 8 - OFF_W - SIZE_W){1'b0}},
                            psize_reg, hoff_reg, byte_out_reg};
    assign m_axis_tuser  = {aend_reg, hdone_reg, kind_reg};
    assign m_axis_tlast  = plast_reg;

    `TASD_ASSERT_NOW(a_offset_only_in_header,
        out_valid_reg && kind_reg != tasd_pkg::KIND_HEADER, hoff_reg == '0)
    `TASD_ASSERT_NOW(a_last_only_on_payload,
        out_valid_reg && plast_reg, kind_reg == tasd_pkg::KIND_PAYLOAD)
    `TASD_ASSERT_NOW(a_header_flags_on_block_end,
        out_valid_reg && (hdone_reg || aend_reg), hoff_reg == LAST_OFF && !(hdone_reg && aend_reg))
    `TASD_ASSERT_NEXT(a_end_is_sticky,
        phase_reg == tasd_pkg::KIND_ENDED && in_valid_reg && advance,
        out_valid_reg && kind_reg == tasd_pkg::KIND_ENDED && phase_reg == tasd_pkg::KIND_ENDED)

endmodule
`default_nettype wire
